>>> sv/bounded_deque_with_delete_top_assert.svh
// Assertion macros used by the deque back end.
`ifndef BOUNDED_DEQUE_WITH_DELETE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DELETE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BDD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Check that cons holds in the cycle after ante.
`define BDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> sv/bdd_pkg.sv
// Shared types and codes for the bounded deque.
package bdd_pkg;

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_DELETE    = 3'd2;
  localparam logic [2:0] KIND_DUMP_FWD  = 3'd3;
  localparam logic [2:0] KIND_DUMP_BWD  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic               ins;
    logic               at_front;
    logic               del;
    logic               backward;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic [4:0]         entries_now;
    logic               last;
  } res_t;

endpackage

>>> sv/bdd_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module bdd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr;
  logic [AW-1:0]    rd;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wr <= (wr == AW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (do_pop) begin
        rd <= (rd == AW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr] <= din;
    end
  end

endmodule

>>> sv/bdd_front.sv
// Front end: takes request beats and sorts them into commands.
module bdd_front (
  input  logic               push,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               full,
  output logic               cmd_push,
  output bdd_pkg::cmd_t      cmd,
  input  logic               cmd_full
);

  logic known;

  always_comb begin
    known        = 1'b1;
    cmd.ins      = 1'b0;
    cmd.at_front = 1'b0;
    cmd.del      = 1'b0;
    cmd.backward = 1'b0;
    cmd.value    = value;
    case (kind)
      bdd_pkg::KIND_INS_FRONT: begin
        cmd.ins      = 1'b1;
        cmd.at_front = 1'b1;
      end
      bdd_pkg::KIND_INS_BACK: begin
        cmd.ins = 1'b1;
      end
      bdd_pkg::KIND_DELETE: begin
        cmd.del = 1'b1;
      end
      bdd_pkg::KIND_DUMP_FWD: begin
        cmd.backward = 1'b0;
      end
      bdd_pkg::KIND_DUMP_BWD: begin
        cmd.backward = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown kinds are taken and dropped.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && known;

endmodule

>>> sv/bdd_back.sv
// Back end: holds the list and carries out inserts, deletes and dumps.
`include "bounded_deque_with_delete_top_assert.svh"

module bdd_back #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  bdd_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           res_push,
  output bdd_pkg::res_t  res,
  input  logic           res_full
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [IW-1:0] STEP_END = IW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic signed [31:0] list      [CAPACITY];
  logic signed [31:0] list_next [CAPACITY];
  logic [CW-1:0]       count, count_next;
  logic [1:0]          state, state_next;
  logic [IW-1:0]       step, step_next;
  logic                backward, backward_next;
  logic [CAPACITY-1:0] match, match_next;
  logic signed [31:0]  del_val, del_val_next;
  logic [CAPACITY-1:0] at_after;
  logic                found;
  logic                emit;
  logic                advance;

  // Mark every place at or after the first match.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_after
    assign at_after[g] = |match[g:0];
  end
  assign found = |match;

  always_comb begin
    emit = backward ? (CW'(step) >= (CAP_C - count)) : (CW'(step) < count);
    advance = !emit || !res_full;
  end

  always_comb begin
    list_next     = list;
    count_next    = count;
    state_next    = state;
    step_next     = step;
    backward_next = backward;
    match_next    = match;
    del_val_next  = del_val;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res.item_value  = cmd.value;
    res.status      = bdd_pkg::ST_OK;
    res.entries_now = 5'(count);
    res.last        = 1'b1;
    case (state)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.ins) begin
            res_push = 1'b1;
            if (count == CAP_C) begin
              res.status = bdd_pkg::ST_FULL;
            end else begin
              if (cmd.at_front) begin
                for (int i = 1; i < CAPACITY; i++) begin
                  list_next[i] = list[i-1];
                end
                list_next[0] = cmd.value;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (count == CW'(i)) begin
                    list_next[i] = cmd.value;
                  end
                end
              end
              count_next      = count + 1'b1;
              res.entries_now = 5'(count + 1'b1);
            end
          end else if (cmd.del) begin
            del_val_next = cmd.value;
            for (int i = 0; i < CAPACITY; i++) begin
              match_next[i] = (list[i] == cmd.value) && (CW'(i) < count);
            end
            state_next = S_DEL;
          end else if (count == '0) begin
            res_push       = 1'b1;
            res.item_value = '0;
            res.status     = bdd_pkg::ST_EMPTY;
          end else begin
            backward_next = cmd.backward;
            step_next     = '0;
            state_next    = S_DUMP;
          end
        end
      end
      S_DEL: begin
        res.item_value = del_val;
        if (!res_full) begin
          res_push = 1'b1;
          if (found) begin
            // Close the gap left by the removed entry.
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (at_after[i]) begin
                list_next[i] = list[i+1];
              end
            end
            count_next      = count - 1'b1;
            res.entries_now = 5'(count - 1'b1);
          end else begin
            res.status = bdd_pkg::ST_NOT_FOUND;
          end
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        // Rotate the whole store once around; emit only on list places.
        if (backward) begin
          res.item_value = list[CAPACITY-1];
          res.last       = (step == STEP_END);
        end else begin
          res.item_value = list[0];
          res.last       = ((CW'(step) + 1'b1) == count);
        end
        if (advance) begin
          res_push = emit;
          if (backward) begin
            for (int i = 1; i < CAPACITY; i++) begin
              list_next[i] = list[i-1];
            end
            list_next[0] = list[CAPACITY-1];
          end else begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              list_next[i] = list[i+1];
            end
            list_next[CAPACITY-1] = list[0];
          end
          step_next = step + 1'b1;
          if (step == STEP_END) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    list     <= list_next;
    step     <= step_next;
    backward <= backward_next;
    match    <= match_next;
    del_val  <= del_val_next;
  end

  `BDD_ASSERT_NOW(a_count_in_range, clk, rst, 1'b1, count <= CAP_C)
  `BDD_ASSERT_NOW(a_push_has_room, clk, rst, res_push, !res_full)
  `BDD_ASSERT_NEXT(a_del_shrinks, clk, rst, state == S_DEL && !res_full && found, count == CW'($past(count) - 1'b1))
  `BDD_ASSERT_NEXT(a_dump_ends, clk, rst, state == S_DUMP && advance && step == STEP_END, state == S_IDLE)

endmodule

>>> sv/bounded_deque_with_delete_top.sv
// Bounded deque with delete by value: an insert passes the command queue, then the result queue.
// Front end and list engine are split by a two-beat command queue; results leave a two-beat queue.
// Inserts sustain one per cycle while the result queue has room; a delete holds the list engine (compare, then shift).
// A dump holds the list engine for a load, then one full rotation of the store.
// Reset (rst, synchronous) empties the list and both queues; entry contents stay undefined.
module bounded_deque_with_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] item_value,
  output logic [1:0]         status,
  output logic [4:0]         entries_now,
  output logic               last
);

  localparam int CMD_W = $bits(bdd_pkg::cmd_t);
  localparam int RES_W = $bits(bdd_pkg::res_t);

  bdd_pkg::cmd_t cmd_in;
  bdd_pkg::cmd_t cmd_out;
  bdd_pkg::res_t res_in;
  bdd_pkg::res_t res_out;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;

  bdd_front u_front (
    .push     (push),
    .kind     (kind),
    .value    (value),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  bdd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (bdd_pkg::CMD_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  bdd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  bdd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (bdd_pkg::RES_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign item_value  = res_out.item_value;
  assign status      = res_out.status;
  assign entries_now = res_out.entries_now;
  assign last        = res_out.last;

endmodule
